@@ design/scpr_pkg.sv @@
// Shared constants and types for the second-chance page replacement unit.
`timescale 1ns / 1ps
package scpr_pkg;

  // Built frame capacity and page number width
  localparam int unsigned MAX_FRAMES = 16;
  localparam int unsigned PAGE_BITS  = 16;

  // Derived widths
  localparam int unsigned SLOT_W   = $clog2(MAX_FRAMES);
  localparam int unsigned CNT_W    = $clog2(MAX_FRAMES + 1);
  localparam int unsigned FC_W     = 5;
  localparam int unsigned STAT_W   = 32;
  localparam int unsigned IN_W     = 16;
  localparam int unsigned OUT_W    = 88;
  localparam int unsigned EVPAGE_W = 16;
  localparam int unsigned OSLOT_W  = 4;

  // Reset value of the frame count register
  localparam logic [FC_W-1:0] FC_RESET = FC_W'(16);

  // Head of the request queue, seen by the back end
  typedef struct packed {
    logic                 valid;
    logic [PAGE_BITS-1:0] page;
  } head_t;

endpackage

@@ design/second_chance_page_replacement_unit.sv @@
// With the back end idle, a hit or an append raises its result in the cycle after
// acceptance; an eviction first runs the clock sweep, one slot per cycle, clearing set
// reference bits until it meets a clear one, and then raises its result. A new reference is
// taken only once the last result has been accepted; a two-entry queue keeps input flowing.
// Reset: asynchronous, active low; empties the ring, clears reference bits, hand and
// counters, and sets frame_count to 16. Resident pages are not cleared.
`timescale 1ns / 1ps
module second_chance_page_replacement_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [scpr_pkg::FC_W-1:0]      cfg_wdata_i,   // frame_count
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [scpr_pkg::IN_W-1:0]      s_axis_tdata_i,  // page_number
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // hit, evicted_valid, evicted_page[16], frame_slot[4], hit_total[32],
  // fault_total[32], two zero bits
  output logic [scpr_pkg::OUT_W-1:0]     m_axis_tdata_o
);

  scpr_pkg::head_t                head;
  logic                           pop;
  logic                           out_hit;
  logic                           out_ev_valid;
  logic [scpr_pkg::EVPAGE_W-1:0]  out_ev_page;
  logic [scpr_pkg::OSLOT_W-1:0]   out_slot;
  logic [scpr_pkg::STAT_W-1:0]    out_hit_total;
  logic [scpr_pkg::STAT_W-1:0]    out_fault_total;

  // Request intake
  scpr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .pop_i           (pop),
    .head_o          (head)
  );

  // Replacement engine
  scpr_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .head_i            (head),
    .pop_o             (pop),
    .out_valid_o       (m_axis_tvalid_o),
    .out_ready_i       (m_axis_tready_i),
    .out_hit_o         (out_hit),
    .out_ev_valid_o    (out_ev_valid),
    .out_ev_page_o     (out_ev_page),
    .out_slot_o        (out_slot),
    .out_hit_total_o   (out_hit_total),
    .out_fault_total_o (out_fault_total)
  );

  // Result packing, highest field first (hit in bit 0)
  assign m_axis_tdata_o = {2'b00, out_fault_total, out_hit_total, out_slot,
                           out_ev_page, out_ev_valid, out_hit};

endmodule

@@ design/scpr_front.sv @@
// Front end: takes page references off the input stream into a two-entry queue.
`timescale 1ns / 1ps
module scpr_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [scpr_pkg::IN_W-1:0]      s_axis_tdata_i,
  input  logic                           pop_i,
  output scpr_pkg::head_t                head_o
);

  logic [scpr_pkg::PAGE_BITS-1:0] entry_q [2];
  logic                           wr_ptr_q, wr_ptr_d;
  logic                           rd_ptr_q, rd_ptr_d;
  logic [1:0]                     count_q, count_d;
  logic                           push;
  logic                           pop;

  assign s_axis_tready_o = (count_q != 2'd2);
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = pop_i && (count_q != 2'd0);

  // Queue pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Page storage, masked to the page width on entry
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= scpr_pkg::PAGE_BITS'(s_axis_tdata_i);
    end
  end

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.page  = entry_q[rd_ptr_q];

endmodule

@@ design/scpr_back.sv @@
// Back end: frame table, clock sweep sequencer, counters and result register.
`timescale 1ns / 1ps
module scpr_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [scpr_pkg::FC_W-1:0]       cfg_wdata_i,
  input  scpr_pkg::head_t                 head_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            out_hit_o,
  output logic                            out_ev_valid_o,
  output logic [scpr_pkg::EVPAGE_W-1:0]   out_ev_page_o,
  output logic [scpr_pkg::OSLOT_W-1:0]    out_slot_o,
  output logic [scpr_pkg::STAT_W-1:0]     out_hit_total_o,
  output logic [scpr_pkg::STAT_W-1:0]     out_fault_total_o
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SWEEP = 1'b1;

  logic                            state_q, state_d;
  logic [scpr_pkg::PAGE_BITS-1:0]  res_q [scpr_pkg::MAX_FRAMES];
  logic [scpr_pkg::MAX_FRAMES-1:0] ref_q, ref_d;
  logic [scpr_pkg::CNT_W-1:0]      filled_q, filled_d;
  logic [scpr_pkg::SLOT_W-1:0]     hand_q, hand_d;
  logic [scpr_pkg::SLOT_W-1:0]     h_q, h_d;
  logic [scpr_pkg::PAGE_BITS-1:0]  page_q, page_d;
  logic [scpr_pkg::STAT_W-1:0]     hit_cnt_q, hit_cnt_d;
  logic [scpr_pkg::STAT_W-1:0]     fault_cnt_q, fault_cnt_d;
  logic [scpr_pkg::FC_W-1:0]       fc_q;

  logic                            out_valid_q, out_valid_d;
  logic                            out_hit_q, out_hit_d;
  logic                            out_ev_valid_q, out_ev_valid_d;
  logic [scpr_pkg::PAGE_BITS-1:0]  out_ev_page_q, out_ev_page_d;
  logic [scpr_pkg::SLOT_W-1:0]     out_slot_q, out_slot_d;

  logic                            res_we;
  logic [scpr_pkg::SLOT_W-1:0]     res_waddr;
  logic [scpr_pkg::PAGE_BITS-1:0]  res_wdata;

  logic [scpr_pkg::CNT_W-1:0]      usable;
  logic [scpr_pkg::MAX_FRAMES-1:0] match;
  logic                            found;
  logic [scpr_pkg::SLOT_W-1:0]     hit_slot;
  logic [scpr_pkg::SLOT_W-1:0]     h_start;
  logic [scpr_pkg::SLOT_W-1:0]     h_next;
  logic [scpr_pkg::STAT_W-1:0]     hit_inc;
  logic [scpr_pkg::STAT_W-1:0]     fault_inc;

  // Frame count clamped to 1..MAX_FRAMES
  always_comb begin
    if (fc_q == '0) begin
      usable = scpr_pkg::CNT_W'(1);
    end else if (32'(fc_q) > 32'(scpr_pkg::MAX_FRAMES)) begin
      usable = scpr_pkg::CNT_W'(scpr_pkg::MAX_FRAMES);
    end else begin
      usable = scpr_pkg::CNT_W'(fc_q);
    end
  end

  // Parallel lookup over the filled frames; a page is resident at most once
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < int'(scpr_pkg::MAX_FRAMES); i++) begin
      match[i] = (scpr_pkg::CNT_W'(i) < filled_q) && (res_q[i] == head_i.page);
      if (match[i]) begin
        hit_slot = hit_slot | scpr_pkg::SLOT_W'(i);
      end
    end
  end
  assign found = |match;

  // Hand wrap at the filled size
  assign h_start = (scpr_pkg::CNT_W'(hand_q) >= filled_q) ? '0 : hand_q;
  assign h_next  = ((scpr_pkg::CNT_W'(h_q) + scpr_pkg::CNT_W'(1)) >= filled_q) ?
                   '0 : (h_q + scpr_pkg::SLOT_W'(1));

  // Saturating counters
  assign hit_inc   = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + 1'b1;
  assign fault_inc = (fault_cnt_q == '1) ? fault_cnt_q : fault_cnt_q + 1'b1;

  // Sequencer
  always_comb begin
    state_d        = state_q;
    ref_d          = ref_q;
    filled_d       = filled_q;
    hand_d         = hand_q;
    h_d            = h_q;
    page_d         = page_q;
    hit_cnt_d      = hit_cnt_q;
    fault_cnt_d    = fault_cnt_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    out_hit_d      = out_hit_q;
    out_ev_valid_d = out_ev_valid_q;
    out_ev_page_d  = out_ev_page_q;
    out_slot_d     = out_slot_q;
    res_we         = 1'b0;
    res_waddr      = '0;
    res_wdata      = head_i.page;
    pop_o          = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (head_i.valid && !out_valid_q) begin
          pop_o = 1'b1;
          if (found) begin
            ref_d[hit_slot] = 1'b1;
            hit_cnt_d       = hit_inc;
            out_valid_d     = 1'b1;
            out_hit_d       = 1'b1;
            out_ev_valid_d  = 1'b0;
            out_ev_page_d   = '0;
            out_slot_d      = hit_slot;
          end else if (filled_q < usable) begin
            // Free frame: append
            res_we                                   = 1'b1;
            res_waddr                                = scpr_pkg::SLOT_W'(filled_q);
            ref_d[scpr_pkg::SLOT_W'(filled_q)]       = 1'b0;
            filled_d                                 = filled_q + 1'b1;
            fault_cnt_d                              = fault_inc;
            out_valid_d                              = 1'b1;
            out_hit_d                                = 1'b0;
            out_ev_valid_d                           = 1'b0;
            out_ev_page_d                            = '0;
            out_slot_d                               = scpr_pkg::SLOT_W'(filled_q);
          end else begin
            page_d  = head_i.page;
            h_d     = h_start;
            state_d = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        if (ref_q[h_q]) begin
          // Second chance: clear and move on
          ref_d[h_q] = 1'b0;
          h_d        = h_next;
        end else begin
          res_we         = 1'b1;
          res_waddr      = h_q;
          res_wdata      = page_q;
          ref_d[h_q]     = 1'b0;
          hand_d         = h_next;
          fault_cnt_d    = fault_inc;
          out_valid_d    = 1'b1;
          out_hit_d      = 1'b0;
          out_ev_valid_d = 1'b1;
          out_ev_page_d  = res_q[h_q];
          out_slot_d     = h_q;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ref_q       <= '0;
      filled_q    <= '0;
      hand_q      <= '0;
      hit_cnt_q   <= '0;
      fault_cnt_q <= '0;
      out_valid_q <= 1'b0;
      fc_q        <= scpr_pkg::FC_RESET;
    end else begin
      state_q     <= state_d;
      ref_q       <= ref_d;
      filled_q    <= filled_d;
      hand_q      <= hand_d;
      hit_cnt_q   <= hit_cnt_d;
      fault_cnt_q <= fault_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        fc_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    h_q            <= h_d;
    page_q         <= page_d;
    out_hit_q      <= out_hit_d;
    out_ev_valid_q <= out_ev_valid_d;
    out_ev_page_q  <= out_ev_page_d;
    out_slot_q     <= out_slot_d;
    if (res_we) begin
      res_q[res_waddr] <= res_wdata;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_hit_o         = out_hit_q;
  assign out_ev_valid_o    = out_ev_valid_q;
  assign out_ev_page_o     = scpr_pkg::EVPAGE_W'(out_ev_page_q);
  assign out_slot_o        = scpr_pkg::OSLOT_W'(out_slot_q);
  assign out_hit_total_o   = hit_cnt_q;
  assign out_fault_total_o = fault_cnt_q;

endmodule

@@ tb/second_chance_page_replacement_unit_test.sv @@
// Self-checking testbench for the second-chance page replacement unit.
`timescale 1ns / 1ps
module second_chance_page_replacement_unit_test;

  // One result transaction; members listed from the top bit down so that the
  // packed layout matches m_axis_tdata_o (hit in bit 0)
  typedef struct packed {
    logic [scpr_pkg::STAT_W-1:0]   fault_total;
    logic [scpr_pkg::STAT_W-1:0]   hit_total;
    logic [scpr_pkg::OSLOT_W-1:0]  frame_slot;
    logic [scpr_pkg::EVPAGE_W-1:0] evicted_page;
    logic                          evicted_valid;
    logic                          hit;
  } outcome_t;

  // Clock-ring model of the unit plus the queue of outcomes still owed
  class page_ring_tracker;
    logic [scpr_pkg::PAGE_BITS-1:0] resident [scpr_pkg::MAX_FRAMES];
    bit                             ref_set  [scpr_pkg::MAX_FRAMES];
    int unsigned                    filled;
    int unsigned                    hand;
    logic [scpr_pkg::STAT_W-1:0]    hits;
    logic [scpr_pkg::STAT_W-1:0]    faults;
    logic [scpr_pkg::FC_W-1:0]      frame_reg;
    outcome_t                       pending_outcomes [$];
    int                             mismatch_count;

    function new();
      foreach (ref_set[i]) ref_set[i] = 1'b0;
      filled         = 0;
      hand           = 0;
      hits           = '0;
      faults         = '0;
      frame_reg      = scpr_pkg::FC_RESET;
      mismatch_count = 0;
    endfunction

    // Work out what one accepted page reference should produce
    function void note_reference(logic [scpr_pkg::PAGE_BITS-1:0] page);
      outcome_t    o;
      int unsigned i;
      int unsigned slot;
      int unsigned usable;
      int unsigned h;
      bit          found;
      o     = '0;
      found = 1'b0;
      slot  = 0;
      for (i = 0; i < filled; i++) begin
        if (resident[i] == page) begin
          slot  = i;
          found = 1'b1;
          break;
        end
      end
      // out-of-range frame counts clamp to 1..MAX_FRAMES
      usable = (frame_reg == 0) ? 1 :
               ((frame_reg > scpr_pkg::MAX_FRAMES) ? scpr_pkg::MAX_FRAMES : frame_reg);
      if (found) begin
        ref_set[slot] = 1'b1;
        if (hits != '1) hits++;
      end else begin
        if (filled < usable) begin
          slot = filled;
          filled++;
        end else begin
          // sweep: give referenced pages a second chance
          h = (hand >= filled) ? 0 : hand;
          while (ref_set[h]) begin
            ref_set[h] = 1'b0;
            h = (h + 1 >= filled) ? 0 : h + 1;
          end
          slot            = h;
          o.evicted_valid = 1'b1;
          o.evicted_page  = resident[h];
          hand            = (h + 1 >= filled) ? 0 : h + 1;
        end
        resident[slot] = page;
        ref_set[slot]  = 1'b0;
        if (faults != '1) faults++;
      end
      o.hit         = found;
      o.frame_slot  = scpr_pkg::OSLOT_W'(slot);
      o.hit_total   = hits;
      o.fault_total = faults;
      pending_outcomes = {pending_outcomes, o};
    endfunction

    task report(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatch_count++;
    endtask

    // Compare a result transaction with the oldest outstanding outcome
    task check_outcome(logic [scpr_pkg::OUT_W-1:0] data);
      outcome_t got;
      outcome_t want;
      got = outcome_t'(data[$bits(outcome_t)-1:0]);
      if (pending_outcomes.size() == 0) begin
        report($sformatf("unexpected result transaction 0x%0h", data));
      end else begin
        want = pending_outcomes.pop_front();
        if (got.hit != want.hit)
          report($sformatf("hit got %0d expected %0d", got.hit, want.hit));
        if (got.evicted_valid != want.evicted_valid)
          report($sformatf("evicted_valid got %0d expected %0d",
                           got.evicted_valid, want.evicted_valid));
        if (got.evicted_page != want.evicted_page)
          report($sformatf("evicted_page got 0x%0h expected 0x%0h",
                           got.evicted_page, want.evicted_page));
        if (got.frame_slot != want.frame_slot)
          report($sformatf("frame_slot got %0d expected %0d",
                           got.frame_slot, want.frame_slot));
        if (got.hit_total != want.hit_total)
          report($sformatf("hit_total got %0d expected %0d", got.hit_total, want.hit_total));
        if (got.fault_total != want.fault_total)
          report($sformatf("fault_total got %0d expected %0d",
                           got.fault_total, want.fault_total));
      end
    endtask
  endclass

  logic                       clk;
  logic                       rst_n     = 1'b0;
  logic                       cfg_we    = 1'b0;
  logic [scpr_pkg::FC_W-1:0]  cfg_wdata = '0;
  logic                       s_valid   = 1'b0;
  logic [scpr_pkg::IN_W-1:0]  s_data    = '0;
  wire                        s_ready;
  wire                        m_valid;
  logic                       m_ready   = 1'b0;
  wire  [scpr_pkg::OUT_W-1:0] m_data;

  bit               gaps_on      = 1'b1;
  int unsigned      hold_request = 0;
  page_ring_tracker tracker      = new();

  second_chance_page_replacement_unit u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: random stalls, plus long hold-offs on request
  initial begin : result_sink
    int unsigned stall;
    int unsigned hold;
    stall = 0;
    hold  = 0;
    forever begin
      @(posedge clk);
      if (m_valid && m_ready) tracker.check_outcome(m_data);
      if (hold_request != 0) begin
        hold         = hold_request;
        hold_request = 0;
      end
      if (hold != 0) begin
        hold--;
        m_ready <= 1'b0;
      end else if (stall != 0) begin
        stall--;
        m_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        stall   = $urandom_range(1, 7) - 1;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // Offer one page reference and wait for the transaction
  task automatic offer_page(input logic [scpr_pkg::IN_W-1:0] page);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= page;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    tracker.note_reference(page);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    s_valid <= 1'b0;
    while (tracker.pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // Frame count write, only with the unit idle
  task automatic set_frames(input logic [scpr_pkg::FC_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we            <= 1'b0;
    tracker.frame_reg = value;
  endtask

  // Random references over a working set sized around the frame count
  task automatic run_phase(input logic [scpr_pkg::FC_W-1:0] frames,
                           input int unsigned count,
                           input bit gaps, input int unsigned hold_at,
                           input int unsigned pause_at);
    logic [scpr_pkg::IN_W-1:0] work_set [$];
    logic [scpr_pkg::IN_W-1:0] page;
    int unsigned               eff;
    int unsigned               ws_size;
    int unsigned               k;
    set_frames(frames);
    gaps_on = gaps;
    eff     = (frames == 0) ? 1 :
              ((frames > scpr_pkg::MAX_FRAMES) ? scpr_pkg::MAX_FRAMES : frames);
    ws_size = eff + $urandom_range(0, eff + 2);
    for (k = 0; k < ws_size; k++) work_set = {work_set, scpr_pkg::IN_W'($urandom)};
    for (k = 0; k < count; k++) begin
      if (k == pause_at) drain();
      if (k == hold_at) hold_request = 60;
      if ($urandom_range(0, 3) == 0) page = scpr_pkg::IN_W'($urandom);
      else page = work_set[$urandom_range(0, ws_size - 1)];
      offer_page(page);
    end
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, hits and appends at the reset frame count
    offer_page(16'h0000);
    offer_page(16'hFFFF);
    offer_page(16'h0000);
    offer_page(16'hAAAA);
    offer_page(16'h5555);
    // frame count below the filled frames: sweep over all four slots
    set_frames(5'd3);
    offer_page(16'h1234);
    offer_page(16'h0000);
    offer_page(16'hAAAA);
    offer_page(16'h5555);
    offer_page(16'h1234);
    // every bit set, so the hand goes right round before evicting
    offer_page(16'h4321);
    // zero acts as one frame
    set_frames(5'd0);
    offer_page(16'h0F0F);
    offer_page(16'h0F0F);
    // raised after the ring is full: appends
    set_frames(5'd8);
    offer_page(16'h00F0);
    offer_page(16'h0F00);
    offer_page(16'hF000);
    // above capacity acts as the full sixteen
    set_frames(5'd31);
    offer_page(16'h8000);
    offer_page(16'h7FFF);

    // Random phases; no idling at all in the last two
    run_phase(5'd16, 130, 1'b1, '1, '1);
    run_phase(5'd1,  130, 1'b1, 40, '1);
    run_phase(5'd2,  130, 1'b1, '1, '1);
    run_phase(5'd5,  130, 1'b0, '1, 50);
    run_phase(5'd31, 130, 1'b1, 70, '1);
    run_phase(5'd17, 130, 1'b1, '1, '1);
    run_phase(5'd0,  130, 1'b1, '1, 30);
    run_phase(5'd7,  130, 1'b1, '1, '1);
    run_phase(5'd12, 130, 1'b1, 20, '1);
    run_phase(5'd4,  130, 1'b0, '1, '1);
    run_phase(5'd16, 130, 1'b0, '1, '1);

    drain();
    repeat (40) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.pending_outcomes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
